// File: hw/rtl/elx_pkg.sv
// Shared types, constants and character-class helpers for the expression lexer.
package elx_pkg;

    // Input length limit and the width of the position counter that reaches it.
    localparam int MAX_CHARS = 65536;
    localparam int POS_W     = $clog2(MAX_CHARS) + 1;
    localparam int START_W   = 16;
    localparam int LEN_W     = 17;

    // Depth of the token queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Token kinds.
    localparam logic [3:0] KIND_NUM   = 4'd0;
    localparam logic [3:0] KIND_MUL   = 4'd1;
    localparam logic [3:0] KIND_DIV   = 4'd2;
    localparam logic [3:0] KIND_ADD   = 4'd3;
    localparam logic [3:0] KIND_SUB   = 4'd4;
    localparam logic [3:0] KIND_NEG   = 4'd5;
    localparam logic [3:0] KIND_AND   = 4'd6;
    localparam logic [3:0] KIND_OR    = 4'd7;
    localparam logic [3:0] KIND_SHR   = 4'd8;
    localparam logic [3:0] KIND_SHL   = 4'd9;
    localparam logic [3:0] KIND_OPEN  = 4'd10;
    localparam logic [3:0] KIND_CLOSE = 4'd11;
    localparam logic [3:0] KIND_ERR   = 4'd12;

    // Number radix codes.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // Pending angle bracket codes.
    localparam logic [1:0] ANG_NONE = 2'd0;
    localparam logic [1:0] ANG_LT   = 2'd1;
    localparam logic [1:0] ANG_GT   = 2'd2;

    // Scanner modes.
    typedef enum logic [8:0] {
        MODE_IDLE  = 9'b000000001,
        MODE_ZERO  = 9'b000000010,
        MODE_DINT  = 9'b000000100,
        MODE_DFRAC = 9'b000001000,
        MODE_HPRE  = 9'b000010000,
        MODE_HEX   = 9'b000100000,
        MODE_BPRE  = 9'b001000000,
        MODE_BIN   = 9'b010000000,
        MODE_SKIP  = 9'b100000000
    } mode_t;

    // One token as it leaves the block.
    typedef struct packed {
        logic [3:0]         kind;
        logic [1:0]         radix;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } token_t;

    // All tokens caused by one character: one or two.
    typedef struct packed {
        logic   two;
        token_t tok0;
        token_t tok1;
    } entry_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return is_dig(c) || (c == "_") || (c == ",");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_bin(input logic [7:0] c);
        return (c == "0") || (c == "1") || (c == "_") || (c == ",");
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Token start offset, saturated to the field width.
    function automatic logic [START_W-1:0] sat_start(input logic [POS_W-1:0] p);
        logic [START_W-1:0] r;
        if (p > POS_W'({START_W{1'b1}})) begin
            r = {START_W{1'b1}};
        end else begin
            r = p[START_W-1:0];
        end
        return r;
    endfunction

    function automatic token_t mk_tok(input logic [3:0] kind, input logic [1:0] radix,
                                      input logic [START_W-1:0] start,
                                      input logic [LEN_W-1:0] length);
        token_t t;
        t.kind   = kind;
        t.radix  = radix;
        t.start  = start;
        t.length = length;
        return t;
    endfunction

    // Token that closes an open number; an empty prefix closes as an error.
    function automatic token_t close_tok(input mode_t mode, input logic [START_W-1:0] st,
                                         input logic [1:0] rad, input logic [POS_W-1:0] stop);
        logic             pre;
        logic [LEN_W-1:0] len;
        pre = (mode == MODE_HPRE) || (mode == MODE_BPRE);
        len = LEN_W'(stop - POS_W'(st));
        return pre ? mk_tok(KIND_ERR, RADIX_DEC, st, len) : mk_tok(KIND_NUM, rad, st, len);
    endfunction

endpackage

// File: hw/rtl/expression_lexer.sv
// Top level of the streaming expression lexer.
//
//   Port group  Dir  Carries                         Marker
//   s_          in   one character request           s_tlast = end of text
//   m_          out  one token request               m_tlast = last token of a character
//
// A character is accepted every cycle while the four-entry token queue has room.
// The scanner state is registered on acceptance; its tokens then pass through the queue
// and the holding register of the back end before m_tvalid rises for the first one.
// A character that yields two tokens sends them one after the other, so the sustained
// input rate is bounded by the token rate of one per cycle while m_tready is high. Reset is
// synchronous; a stalled m_ side fills the queue and then drops s_tready, with no
// request lost.
module expression_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] token_kind, [5:4] number_radix,
                                   // [21:6] token_start, [38:22] token_length, [39] zero
    output logic        m_tlast
);
    import elx_pkg::*;

    logic   in_fire, push, full, pop, q_valid;
    entry_t push_entry, q_entry;
    token_t out_tok;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    elx_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .push_entry  (push_entry)
    );

    elx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .rd_valid   (q_valid),
        .rd_entry   (q_entry)
    );

    elx_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    // Pack the token fields, lowest field first.
    assign m_tdata = {1'b0, out_tok.length, out_tok.start, out_tok.radix, out_tok.kind};

endmodule

// File: hw/rtl/elx_front.sv
// Front end: takes one character per cycle while the queue has room, runs the scanner and forms token entries.
module elx_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,     // a character request is accepted this cycle
    input  logic [7:0]      ch,
    input  logic            end_of_text,
    output logic            push,
    output elx_pkg::entry_t push_entry
);
    import elx_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [START_W-1:0] st_reg, st_next;
    logic [1:0]         rad_reg, rad_next;
    logic [1:0]         ang_reg, ang_next;
    logic               lwo_reg, lwo_next;

    logic [1:0] n;
    token_t     tok0, tok1, t;
    logic       in_num, overflow, ext, do_fresh, pre;
    mode_t      ext_mode;
    logic [1:0] ext_rad;
    logic [3:0] kind;
    logic       single;

    // Whether the open number can take this character, and the mode it moves to.
    always_comb begin
        ext      = 1'b0;
        ext_mode = mode_reg;
        ext_rad  = rad_reg;
        case (mode_reg)
            MODE_ZERO: begin
                if ((ch == "x") || (ch == "X")) begin
                    ext = 1'b1; ext_mode = MODE_HPRE; ext_rad = RADIX_HEX;
                end else if ((ch == "b") || (ch == "B")) begin
                    ext = 1'b1; ext_mode = MODE_BPRE; ext_rad = RADIX_BIN;
                end else if (is_dec(ch)) begin
                    ext = 1'b1; ext_mode = MODE_DINT;
                end else if (ch == ".") begin
                    ext = 1'b1; ext_mode = MODE_DFRAC;
                end
            end
            MODE_DINT: begin
                if (is_dec(ch)) begin
                    ext = 1'b1;
                end else if (ch == ".") begin
                    ext = 1'b1; ext_mode = MODE_DFRAC;
                end
            end
            MODE_DFRAC: begin
                ext = is_dec(ch);
            end
            MODE_HPRE, MODE_HEX: begin
                if (is_hex(ch)) begin
                    ext = 1'b1; ext_mode = MODE_HEX;
                end
            end
            MODE_BPRE, MODE_BIN: begin
                if (is_bin(ch)) begin
                    ext = 1'b1; ext_mode = MODE_BIN;
                end
            end
            default: begin
                ext = 1'b0;
            end
        endcase
    end

    // Scanner step for one character, emitting at most two tokens.
    always_comb begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        st_next   = st_reg;
        rad_next  = rad_reg;
        ang_next  = ang_reg;
        lwo_next  = lwo_reg;
        n         = 2'd0;
        tok0      = '0;
        tok1      = '0;
        t         = '0;
        do_fresh  = 1'b0;
        kind      = KIND_ERR;
        single    = 1'b0;
        pre       = 1'b0;
        in_num    = (mode_reg != MODE_IDLE) && (mode_reg != MODE_SKIP);
        overflow  = pos_reg >= POS_W'(MAX_CHARS);

        if (mode_reg == MODE_SKIP) begin
            // Everything up to the end of the text is ignored.
        end else if (overflow || (in_num && !ext)) begin
            // Close the open number before this character.
            if (in_num) begin
                t   = close_tok(mode_reg, st_reg, rad_reg, pos_reg);
                pre = (mode_reg == MODE_HPRE) || (mode_reg == MODE_BPRE);
                mode_next = pre ? MODE_SKIP : MODE_IDLE;
                if (!pre) begin
                    lwo_next = 1'b1;
                end
                rad_next = RADIX_DEC;
                tok0 = t;
                n    = 2'd1;
            end
            if (overflow) begin
                ang_next  = ANG_NONE;
                t         = mk_tok(KIND_ERR, RADIX_DEC, sat_start(pos_reg), LEN_W'(1));
                mode_next = MODE_SKIP;
                if (n == 2'd0) begin
                    tok0 = t;
                end else begin
                    tok1 = t;
                end
                n = n + 2'd1;
            end else if (mode_next == MODE_IDLE) begin
                do_fresh = 1'b1;
            end
        end else if (in_num) begin
            mode_next = ext_mode;
            rad_next  = ext_rad;
        end else if (ang_reg != ANG_NONE) begin
            // A pending angle either doubles into a shift or is dropped.
            ang_next = ANG_NONE;
            if (((ang_reg == ANG_LT) && (ch == "<")) || ((ang_reg == ANG_GT) && (ch == ">"))) begin
                lwo_next = 1'b0;
                tok0 = mk_tok((ang_reg == ANG_LT) ? KIND_SHL : KIND_SHR, RADIX_DEC, st_reg,
                              LEN_W'(2));
                n    = 2'd1;
            end else begin
                do_fresh = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        // Lex a character from the idle mode.
        if (do_fresh && !is_ws(ch)) begin
            single = 1'b1;
            case (ch)
                "*": kind = KIND_MUL;
                "/": kind = KIND_DIV;
                "+": kind = KIND_ADD;
                "&": kind = KIND_AND;
                "|": kind = KIND_OR;
                "(": kind = KIND_OPEN;
                ")": kind = KIND_CLOSE;
                "-": kind = lwo_next ? KIND_SUB : KIND_NEG;
                "<": begin
                    single   = 1'b0;
                    ang_next = ANG_LT;
                    st_next  = pos_reg[START_W-1:0];
                end
                ">": begin
                    single   = 1'b0;
                    ang_next = ANG_GT;
                    st_next  = pos_reg[START_W-1:0];
                end
                default: begin
                    if (is_dig(ch)) begin
                        single    = 1'b0;
                        st_next   = pos_reg[START_W-1:0];
                        rad_next  = RADIX_DEC;
                        mode_next = (ch == "0") ? MODE_ZERO : MODE_DINT;
                    end else begin
                        kind      = KIND_ERR;
                        mode_next = MODE_SKIP;
                    end
                end
            endcase
            if (single) begin
                if (kind != KIND_ERR) begin
                    lwo_next = (kind == KIND_CLOSE);
                end
                t = mk_tok(kind, RADIX_DEC, sat_start(pos_reg), LEN_W'(1));
                if (n == 2'd0) begin
                    tok0 = t;
                end else begin
                    tok1 = t;
                end
                n = n + 2'd1;
            end
        end

        if (!overflow) begin
            pos_next = pos_reg + POS_W'(1);
        end

        // End of text closes an open number and restores the reset state.
        if (end_of_text) begin
            if ((mode_next != MODE_IDLE) && (mode_next != MODE_SKIP)) begin
                t = close_tok(mode_next, st_next, rad_next, pos_next);
                if (n == 2'd0) begin
                    tok0 = t;
                end else begin
                    tok1 = t;
                end
                n = n + 2'd1;
            end
            mode_next = MODE_IDLE;
            pos_next  = '0;
            st_next   = '0;
            rad_next  = RADIX_DEC;
            ang_next  = ANG_NONE;
            lwo_next  = 1'b0;
        end
    end

    assign push            = in_fire && (n != 2'd0);
    assign push_entry.two  = n[1];
    assign push_entry.tok0 = tok0;
    assign push_entry.tok1 = tok1;

    // Scanner state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            st_reg   <= '0;
            rad_reg  <= RADIX_DEC;
            ang_reg  <= ANG_NONE;
            lwo_reg  <= 1'b0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            st_reg   <= st_next;
            rad_reg  <= rad_next;
            ang_reg  <= ang_next;
            lwo_reg  <= lwo_next;
        end
    end

endmodule

// File: hw/rtl/elx_queue.sv
// Short queue of token entries between the front end and the back end.
module elx_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  elx_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output elx_pkg::entry_t rd_entry
);
    import elx_pkg::*;

    entry_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/elx_back.sv
// Back end: holds one entry and sends its tokens one per cycle while out_ready is high.
module elx_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  elx_pkg::entry_t       q_entry,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output elx_pkg::token_t       out_tok,
    output logic                  out_last
);
    import elx_pkg::*;

    entry_t hold_reg;
    logic   hold_valid_reg, hold_valid_next;
    logic   idx_reg, idx_next;
    logic   load;

    assign out_valid = hold_valid_reg;
    assign out_tok   = idx_reg ? hold_reg.tok1 : hold_reg.tok0;
    assign out_last  = (idx_reg == hold_reg.two);

    // Take the next entry when the holder is empty or its last token leaves.
    always_comb begin
        load            = q_valid && (!hold_valid_reg || (out_ready && out_last));
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        if (load) begin
            hold_valid_next = 1'b1;
            idx_next        = 1'b0;
        end else if (hold_valid_reg && out_ready) begin
            if (out_last) begin
                hold_valid_next = 1'b0;
            end else begin
                idx_next = 1'b1;
            end
        end
    end

    assign q_pop = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= q_entry;
        end
    end

endmodule

// File: tb/expression_lexer_tb.sv
// Self-checking testbench for the streaming expression lexer.
`timescale 1ns / 1ps

module expression_lexer_tb;
    import elx_pkg::*;

    // Clock, reset and the two request channels.
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;  // [7:0] ch
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [3:0] token_kind, [5:4] number_radix,
                                   // [21:6] token_start, [38:22] token_length, [39] zero
    logic        m_tlast;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_CHARS = 1700;

    // One expected token and the flag that marks the last token of its character.
    typedef struct packed {
        token_t tok;
        logic   last;
    } tok_rec_t;

    // One row of the directed table; the token fields count only when typed is set.
    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        typed;
        logic [3:0]  kind;
        logic [1:0]  radix;
        logic [15:0] start;
        logic [16:0] len;
    } stim_row_t;

    // Receiver stall styles.
    typedef enum logic [2:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY,
        RX_BLOCKS
    } rx_style_t;

    // Lexer state mirrored by the predictor.
    mode_t       lx_mode;
    logic [16:0] lx_pos;
    logic [15:0] lx_start;
    logic [1:0]  lx_radix;
    logic [1:0]  lx_angle;
    logic        lx_operand;

    tok_rec_t    char_toks[$];   // tokens caused by the character just lexed
    tok_rec_t    tokens_due[$];  // tokens still to arrive on the result channel
    logic [7:0]  expr_chars[$];  // characters of the expression being built
    stim_row_t   dir_rows [0:26];

    int unsigned mismatches    = 0;
    int unsigned lexed_items   = 0;
    int unsigned ignored_items = 0;
    int unsigned tokens_seen   = 0;
    int unsigned cycles        = 0;
    int          burst_left    = 0;
    bit          steady        = 1'b0;

    logic [15:0] stall_tick  = 16'd0;
    rx_style_t   rx_style    = RX_OPEN;

    string dec_set = "0123456789_,";
    string hex_set = "0123456789abcdefABCDEF_,";
    string bin_set = "01_,";
    string op_set  = "*/+-&|()";
    string ws_set  = "\011\012\013\014\015 ";

    expression_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Print one line per mismatch (only the first few) and count every one.
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatches < 40) begin
            $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
        mismatches++;
    endtask

    // Character classes of the lexer.
    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit dec_char(input logic [7:0] c);
        return digit_char(c) || c == "_" || c == ",";
    endfunction

    function automatic bit hex_char(input logic [7:0] c);
        return dec_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit bin_char(input logic [7:0] c);
        return c == "0" || c == "1" || c == "_" || c == ",";
    endfunction

    function automatic bit space_char(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit number_open();
        return lx_mode != MODE_IDLE && lx_mode != MODE_SKIP;
    endfunction

    function automatic void lexer_clear();
        lx_mode    = MODE_IDLE;
        lx_pos     = '0;
        lx_start   = '0;
        lx_radix   = RADIX_DEC;
        lx_angle   = ANG_NONE;
        lx_operand = 1'b0;
    endfunction

    // Append a token, with start and length saturated to their field widths.
    function automatic void put_tok(input logic [3:0] kind, input logic [1:0] radix,
                                    input int unsigned start, input int unsigned len);
        tok_rec_t r;
        r.tok.kind   = kind;
        r.tok.radix  = radix;
        r.tok.start  = (start > 32'hFFFF) ? 16'hFFFF : 16'(start);
        r.tok.length = (len > 32'h1FFFF) ? 17'h1FFFF : 17'(len);
        r.last       = 1'b0;
        char_toks    = {char_toks, r};
    endfunction

    // Close the open number that ends just before offset stop.
    function automatic void close_num(input int unsigned stop);
        if (lx_mode == MODE_HPRE || lx_mode == MODE_BPRE) begin
            // A prefix with no digit after it is an error.
            put_tok(KIND_ERR, RADIX_DEC, 32'(lx_start), stop - 32'(lx_start));
            lx_mode = MODE_SKIP;
        end else begin
            put_tok(KIND_NUM, lx_radix, 32'(lx_start), stop - 32'(lx_start));
            lx_operand = 1'b1;
            lx_mode    = MODE_IDLE;
        end
        lx_radix = RADIX_DEC;
    endfunction

    // Lex a character with no number open and no angle pending.
    function automatic void lex_fresh(input logic [7:0] c, input int unsigned p);
        logic [3:0] kind;
        if (space_char(c)) begin
            return;
        end
        case (c)
            "*": kind = KIND_MUL;
            "/": kind = KIND_DIV;
            "+": kind = KIND_ADD;
            "&": kind = KIND_AND;
            "|": kind = KIND_OR;
            "(": kind = KIND_OPEN;
            ")": kind = KIND_CLOSE;
            "-": kind = lx_operand ? KIND_SUB : KIND_NEG;
            "<": begin
                lx_angle = ANG_LT;
                lx_start = 16'(p);
                return;
            end
            ">": begin
                lx_angle = ANG_GT;
                lx_start = 16'(p);
                return;
            end
            default: begin
                if (digit_char(c)) begin
                    lx_start = 16'(p);
                    lx_radix = RADIX_DEC;
                    lx_mode  = (c == "0") ? MODE_ZERO : MODE_DINT;
                end else begin
                    put_tok(KIND_ERR, RADIX_DEC, p, 1);
                    lx_mode = MODE_SKIP;
                end
                return;
            end
        endcase
        lx_operand = (kind == KIND_CLOSE);
        put_tok(kind, RADIX_DEC, p, 1);
    endfunction

    // Grow the open number by c; false if c cannot belong to it.
    function automatic bit extend_number(input logic [7:0] c);
        case (lx_mode)
            MODE_ZERO: begin
                if (c == "x" || c == "X") begin
                    lx_mode  = MODE_HPRE;
                    lx_radix = RADIX_HEX;
                    return 1'b1;
                end
                if (c == "b" || c == "B") begin
                    lx_mode  = MODE_BPRE;
                    lx_radix = RADIX_BIN;
                    return 1'b1;
                end
                if (dec_char(c)) begin
                    lx_mode = MODE_DINT;
                    return 1'b1;
                end
                if (c == ".") begin
                    lx_mode = MODE_DFRAC;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_DINT: begin
                if (dec_char(c)) begin
                    return 1'b1;
                end
                if (c == ".") begin
                    lx_mode = MODE_DFRAC;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_DFRAC: return dec_char(c);
            MODE_HPRE, MODE_HEX: begin
                if (hex_char(c)) begin
                    lx_mode = MODE_HEX;
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_BPRE, MODE_BIN: begin
                if (bin_char(c)) begin
                    lx_mode = MODE_BIN;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Predict the tokens that one accepted character causes, into char_toks.
    function automatic void lex_char(input logic [7:0] c, input logic eot);
        int unsigned p;
        bit          in_num;
        p      = 32'(lx_pos);
        in_num = number_open();
        char_toks.delete();

        if (lx_mode == MODE_SKIP) begin
            // Everything after an error waits for the end of the text.
        end else if (p >= MAX_CHARS) begin
            // Past the length limit: close any number, then flag the overflow.
            if (in_num) begin
                close_num(p);
            end
            lx_angle = ANG_NONE;
            put_tok(KIND_ERR, RADIX_DEC, p, 1);
            lx_mode = MODE_SKIP;
        end else if (in_num) begin
            if (!extend_number(c)) begin
                close_num(p);
                if (lx_mode == MODE_IDLE) begin
                    lex_fresh(c, p);
                end
            end
        end else if (lx_angle != ANG_NONE) begin
            // A doubled angle makes a shift; a lone one is dropped.
            if (c == ((lx_angle == ANG_LT) ? "<" : ">")) begin
                lx_operand = 1'b0;
                put_tok((lx_angle == ANG_LT) ? KIND_SHL : KIND_SHR, RADIX_DEC,
                        32'(lx_start), 2);
                lx_angle = ANG_NONE;
            end else begin
                lx_angle = ANG_NONE;
                lex_fresh(c, p);
            end
        end else begin
            lex_fresh(c, p);
        end

        if (p < MAX_CHARS) begin
            lx_pos = 17'(p + 1);
        end

        // End of text closes an open number and starts the next expression afresh.
        if (eot) begin
            if (number_open()) begin
                close_num(32'(lx_pos));
            end
            lexer_clear();
        end

        if (char_toks.size() > 0) begin
            char_toks[char_toks.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Add one character to the end of the expression being built.
    function automatic void append_char(input logic [7:0] c);
        expr_chars = {expr_chars, c};
    endfunction

    // Append one random piece of an expression; noisy pieces may break it.
    function automatic void add_piece(input bit noisy);
        int sel;
        sel = $urandom_range(0, 99);
        if (noisy && sel < 20) begin
            case ($urandom_range(0, 3))
                0: append_char(8'($urandom_range(0, 255)));
                1: append_char($urandom_range(0, 1) ? "<" : ">");
                2: begin
                    append_char("0");
                    append_char(pick("xXbB"));
                end
                default: begin
                    append_char(pick("123456789"));
                    append_char(pick("xXgz.#"));
                end
            endcase
        end else if (sel < 40) begin
            case ($urandom_range(0, 2))
                0: begin
                    append_char(pick("0123456789"));
                    repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 5)) begin
                        append_char(pick(dec_set));
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        append_char(".");
                        repeat ($urandom_range(0, 4)) append_char(pick(dec_set));
                    end
                end
                1: begin
                    append_char("0");
                    append_char(pick("xX"));
                    repeat ($urandom_range(1, 8)) append_char(pick(hex_set));
                end
                default: begin
                    append_char("0");
                    append_char(pick("bB"));
                    repeat ($urandom_range(1, 12)) append_char(pick(bin_set));
                end
            endcase
        end else if (sel < 75) begin
            append_char(pick(op_set));
        end else if (sel < 85) begin
            if ($urandom_range(0, 1)) begin
                append_char("<");
                append_char("<");
            end else begin
                append_char(">");
                append_char(">");
            end
        end else begin
            append_char(pick(ws_set));
        end
    endfunction

    // Offer one character in random bursts, then predict its tokens once accepted.
    task automatic send_char(input logic [7:0] c, input logic eot, input logic typed,
                             input token_t want);
        bit     ignored;
        token_t got;
        if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);

        ignored = (lx_mode == MODE_SKIP);
        lex_char(c, eot);
        if (ignored) begin
            ignored_items++;
        end else begin
            lexed_items++;
        end
        tokens_due = {tokens_due, char_toks};

        // Rows with a typed token must agree with the prediction as well.
        if (typed) begin
            if (char_toks.size() != 1) begin
                report_mismatch("token count of a directed character", 64'(1),
                                64'(char_toks.size()));
            end else begin
                got = char_toks[0].tok;
                if (got != want) begin
                    report_mismatch("directed token", 64'(want), 64'(got));
                end
            end
        end
    endtask

    // Hold the sender off until every predicted token has arrived.
    task automatic drain_tokens();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tokens_due.size() != 0);
    endtask

    // Receiver readiness follows a style that is redrawn whenever the low nine bits of stall_tick wrap to zero.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 16'd1;
        if (stall_tick[8:0] == 9'd0) begin
            rx_style <= rx_style_t'($urandom_range(0, 4));
        end
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (stall_tick[1:0] == 2'd3);
            RX_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
            default:   m_tready <= (stall_tick[4:3] != 2'd0);
        endcase
    end

    // Compare every accepted token with the oldest prediction.
    always @(posedge aclk) begin : check_tokens
        tok_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            tokens_seen++;
            if (tokens_due.size() == 0) begin
                report_mismatch("token with none expected, kind", 64'(0), 64'(m_tdata[3:0]));
            end else begin
                want = tokens_due.pop_front();
                if (m_tdata[3:0] != want.tok.kind)
                    report_mismatch("token_kind", 64'(want.tok.kind), 64'(m_tdata[3:0]));
                if (m_tdata[5:4] != want.tok.radix)
                    report_mismatch("number_radix", 64'(want.tok.radix), 64'(m_tdata[5:4]));
                if (m_tdata[21:6] != want.tok.start)
                    report_mismatch("token_start", 64'(want.tok.start), 64'(m_tdata[21:6]));
                if (m_tdata[38:22] != want.tok.length)
                    report_mismatch("token_length", 64'(want.tok.length),
                                    64'(m_tdata[38:22]));
                if (m_tdata[39] != 1'b0)
                    report_mismatch("tdata pad bit", 64'(0), 64'(m_tdata[39]));
                if (m_tlast != want.last)
                    report_mismatch("run_last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out with %0d tokens outstanding.", tokens_due.size());
            $display("expression_lexer test failed");
            $finish;
        end
    end

    initial begin : stimulus
        token_t      want;
        int unsigned goal;
        bit          noisy;

        // Directed table: every token kind, shifts, lone angles and error cases.
        dir_rows[0]  = '{"*", 1'b0, 1'b1, KIND_MUL,   RADIX_DEC, 16'd0,  17'd1};
        dir_rows[1]  = '{"(", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[2]  = '{"0", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[3]  = '{"x", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[4]  = '{"F", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[5]  = '{")", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[6]  = '{"-", 1'b0, 1'b1, KIND_SUB,   RADIX_DEC, 16'd6,  17'd1};
        dir_rows[7]  = '{"-", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[8]  = '{"<", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[9]  = '{"<", 1'b0, 1'b1, KIND_SHL,   RADIX_DEC, 16'd8,  17'd2};
        dir_rows[10] = '{">", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[11] = '{">", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[12] = '{">", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[13] = '{"+", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[14] = '{"0", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[15] = '{"b", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[16] = '{"2", 1'b0, 1'b1, KIND_ERR,   RADIX_DEC, 16'd14, 17'd2};
        dir_rows[17] = '{"/", 1'b1, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[18] = '{"5", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[19] = '{"x", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[20] = '{" ", 1'b1, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[21] = '{"9", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[22] = '{".", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[23] = '{"_", 1'b1, 1'b1, KIND_NUM,   RADIX_DEC, 16'd0,  17'd3};
        dir_rows[24] = '{"&", 1'b0, 1'b1, KIND_AND,   RADIX_DEC, 16'd0,  17'd1};
        dir_rows[25] = '{"|", 1'b0, 1'b0, KIND_NUM,   RADIX_DEC, 16'd0,  17'd0};
        dir_rows[26] = '{"/", 1'b1, 1'b1, KIND_DIV,   RADIX_DEC, 16'd2,  17'd1};

        lexer_clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            want.kind   = dir_rows[i].kind;
            want.radix  = dir_rows[i].radix;
            want.start  = dir_rows[i].start;
            want.length = dir_rows[i].len;
            send_char(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, want);
        end
        drain_tokens();

        // Two inputs past the length limit, sent back to back: the first closes an
        // empty hex prefix at the limit, the second a number of the longest length.
        steady = 1'b1;
        repeat (MAX_CHARS - 2) send_char(" ", 1'b0, 1'b0, '0);
        send_char("0", 1'b0, 1'b0, '0);
        send_char("x", 1'b0, 1'b0, '0);
        send_char("+", 1'b1, 1'b0, '0);
        send_char("1", 1'b0, 1'b0, '0);
        repeat (MAX_CHARS - 1) send_char(pick(dec_set), 1'b0, 1'b0, '0);
        send_char("9", 1'b0, 1'b0, '0);
        send_char(")", 1'b1, 1'b0, '0);
        steady = 1'b0;
        drain_tokens();

        // Random expressions, mostly well formed, some with noise.
        goal = lexed_items + RANDOM_CHARS;
        while (lexed_items < goal) begin
            expr_chars.delete();
            noisy = ($urandom_range(0, 99) < 30);
            repeat ($urandom_range(1, 20)) add_piece(noisy);
            foreach (expr_chars[i]) begin
                send_char(expr_chars[i], i == expr_chars.size() - 1, 1'b0, '0);
            end
        end

        drain_tokens();
        repeat (20) @(posedge aclk);

        $display("Sent %0d characters to the lexer and %0d that fell after an error; %0d tokens.",
                 lexed_items, ignored_items, tokens_seen);
        $display("Covered all token kinds, shifts, lone angles, prefixes and the length limit.");
        if (mismatches == 0 && tokens_due.size() == 0) begin
            $display("expression_lexer test passed");
        end else begin
            $display("expression_lexer test failed");
        end
        $finish;
    end

endmodule
